>>> design/biphasic_pulse_sequencer_top_macros.svh
// Assertion macros used by the checker file.
`ifndef BIPHASIC_PULSE_SEQUENCER_TOP_MACROS_SVH
`define BIPHASIC_PULSE_SEQUENCER_TOP_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define BPS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Check a consequent in the cycle after its antecedent.
`define BPS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

>>> design/bps_pkg.sv
package bps_pkg;

	// coarse timer width
	localparam int TimeBits = 16;
	// width used when comparing elapsed time with a 16-bit register
	localparam int CmpBits = (TimeBits > 16) ? TimeBits : 16;

	// sequencer phases
	localparam logic [2:0] PhIdle    = 3'd0;
	localparam logic [2:0] PhPreWait = 3'd1;
	localparam logic [2:0] PhPos     = 3'd2;
	localparam logic [2:0] PhGap     = 3'd3;
	localparam logic [2:0] PhNeg     = 3'd4;
	localparam logic [2:0] PhPeriod  = 3'd5;

	// drive polarity
	localparam logic [1:0] DriveOff = 2'd0;
	localparam logic [1:0] DrivePos = 2'd1;
	localparam logic [1:0] DriveNeg = 2'd2;

	// run flag values
	localparam logic [7:0] FlagOff   = 8'd0;
	localparam logic [7:0] FlagStart = 8'd1;
	localparam logic [7:0] FlagRun   = 8'd2;
	localparam logic [7:0] FlagMax   = 8'd3;

	// measurement slots
	localparam logic [1:0] Slot0 = 2'd0;
	localparam logic [1:0] Slot1 = 2'd1;
	localparam logic [1:0] Slot2 = 2'd2;
	localparam logic [1:0] Slot3 = 2'd3;

	// register indexes
	localparam logic [2:0] RegPreWait = 3'd0;
	localparam logic [2:0] RegPosW    = 3'd1;
	localparam logic [2:0] RegGapW    = 3'd2;
	localparam logic [2:0] RegNegW    = 3'd3;
	localparam logic [2:0] RegPeriod  = 3'd4;
	localparam logic [2:0] RegPosLvl  = 3'd5;
	localparam logic [2:0] RegNegLvl  = 3'd6;

	typedef struct packed {
		logic [15:0] pre_wait_time;
		logic [15:0] positive_width;
		logic [15:0] gap_width;
		logic [15:0] negative_width;
		logic [15:0] pulse_period;
		logic [7:0]  positive_level;
		logic [7:0]  negative_level;
	} cfg_t;

	typedef struct packed {
		logic [1:0] drive;
		logic [7:0] level;
		logic       sample_start;
		logic       sample_store;
		logic [1:0] sample_slot;
		logic       indicator;
		logic       report;
		logic [7:0] run_flag;
		logic [2:0] phase;
	} res_t;

endpackage

>>> design/bps_cfg.sv
module bps_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output bps_pkg::cfg_t      cfg
);

	bps_pkg::cfg_t cfg_q;

	// hold the register file; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pre_wait_time  <= 16'd1000;
			cfg_q.positive_width <= 16'd50;
			cfg_q.gap_width      <= 16'd50;
			cfg_q.negative_width <= 16'd50;
			cfg_q.pulse_period   <= 16'd1000;
			cfg_q.positive_level <= 8'd25;
			cfg_q.negative_level <= 8'd25;
		end else if (cfg_valid) begin
			case (cfg_index)
				bps_pkg::RegPreWait: cfg_q.pre_wait_time  <= cfg_data;
				bps_pkg::RegPosW:    cfg_q.positive_width <= cfg_data;
				bps_pkg::RegGapW:    cfg_q.gap_width      <= cfg_data;
				bps_pkg::RegNegW:    cfg_q.negative_width <= cfg_data;
				bps_pkg::RegPeriod:  cfg_q.pulse_period   <= cfg_data;
				bps_pkg::RegPosLvl:  cfg_q.positive_level <= cfg_data[7:0];
				bps_pkg::RegNegLvl:  cfg_q.negative_level <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> design/bps_core.sv
module bps_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic          timer_advance,
	input  logic          flag_write,
	input  logic [7:0]    flag_value,
	input  bps_pkg::cfg_t cfg,
	output bps_pkg::res_t res
);

	logic [2:0]                   phase_q, n_phase, ph;
	logic [7:0]                   flag_q, wr_flag, n_flag;
	logic [bps_pkg::TimeBits-1:0] ctime_q, n_ctime, mark_q, n_mark, elapsed;
	logic [15:0]                  fine_q, n_fine;
	logic                         pre_done, period_done;

	// take the software write and the timer tick first
	always_comb begin
		wr_flag = flag_write ? flag_value : flag_q;
		n_ctime = timer_advance ? bps_pkg::TimeBits'(ctime_q + 1'b1) : ctime_q;
		ph      = ((wr_flag == bps_pkg::FlagOff) || (wr_flag > bps_pkg::FlagMax)) ?
		          bps_pkg::PhIdle : phase_q;
		elapsed = bps_pkg::TimeBits'(n_ctime - mark_q);
	end

	assign pre_done    = bps_pkg::CmpBits'(elapsed) >= bps_pkg::CmpBits'(cfg.pre_wait_time);
	assign period_done = bps_pkg::CmpBits'(elapsed) >= bps_pkg::CmpBits'(cfg.pulse_period);

	// advance the phase sequencer by one tick
	always_comb begin
		n_phase = ph;
		n_flag  = wr_flag;
		n_mark  = mark_q;
		n_fine  = fine_q;
		res     = '0;
		case (ph)
			bps_pkg::PhIdle: begin
				if (wr_flag == bps_pkg::FlagStart) begin
					n_phase = bps_pkg::PhPreWait;
					n_mark  = n_ctime;
				end else begin
					n_flag = bps_pkg::FlagOff;
				end
			end
			bps_pkg::PhPreWait: begin
				if (pre_done) begin
					n_flag  = bps_pkg::FlagRun;
					n_mark  = n_ctime;
					n_phase = bps_pkg::PhPos;
					n_fine  = '0;
				end
			end
			bps_pkg::PhPos: begin
				res.indicator = 1'b1;
				res.level     = cfg.positive_level;
				if (fine_q >= cfg.positive_width) begin
					res.sample_store = 1'b1;
					res.sample_slot  = bps_pkg::Slot0;
					res.sample_start = 1'b1;
					n_phase = bps_pkg::PhGap;
					n_fine  = '0;
				end else begin
					res.drive        = bps_pkg::DrivePos;
					res.sample_start = (fine_q == '0);
					n_fine = 16'(fine_q + 1'b1);
				end
			end
			bps_pkg::PhGap: begin
				res.indicator = 1'b1;
				if (fine_q >= cfg.gap_width) begin
					res.sample_store = 1'b1;
					res.sample_slot  = bps_pkg::Slot1;
					res.level        = cfg.negative_level;
					n_fine = '0;
					if (cfg.negative_width != '0) begin
						n_phase = bps_pkg::PhNeg;
					end else begin
						// no negative phase: the gap boundary ends the pulse
						n_phase    = bps_pkg::PhPeriod;
						n_mark     = n_ctime;
						res.report = 1'b1;
					end
				end else begin
					res.level = cfg.positive_level;
					n_fine = 16'(fine_q + 1'b1);
				end
			end
			bps_pkg::PhNeg: begin
				res.indicator = 1'b1;
				res.level     = cfg.negative_level;
				if (fine_q >= cfg.negative_width) begin
					res.sample_store = 1'b1;
					res.sample_slot  = bps_pkg::Slot2;
					res.sample_start = 1'b1;
					n_phase = bps_pkg::PhPeriod;
					n_mark  = n_ctime;
					// mark the slot 3 store as pending
					n_fine  = 16'd1;
				end else begin
					res.drive        = bps_pkg::DriveNeg;
					res.sample_start = (fine_q == '0);
					n_fine = 16'(fine_q + 1'b1);
				end
			end
			bps_pkg::PhPeriod: begin
				if (fine_q == 16'd1) begin
					res.sample_store = 1'b1;
					res.sample_slot  = bps_pkg::Slot3;
					res.report       = 1'b1;
					n_fine = '0;
				end
				if (period_done) begin
					n_phase = bps_pkg::PhPos;
					n_mark  = n_ctime;
					n_fine  = '0;
				end
			end
			default: begin
				n_phase = bps_pkg::PhIdle;
			end
		endcase
		res.run_flag = n_flag;
		res.phase    = n_phase;
	end

	// update the state on each accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bps_pkg::PhIdle;
			flag_q  <= '0;
			ctime_q <= '0;
			mark_q  <= '0;
			fine_q  <= '0;
		end else if (step) begin
			phase_q <= n_phase;
			flag_q  <= n_flag;
			ctime_q <= n_ctime;
			mark_q  <= n_mark;
			fine_q  <= n_fine;
		end
	end

endmodule

>>> design/bps_outbuf.sv
module bps_outbuf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bps_pkg::res_t push_data,
	output logic          push_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output bps_pkg::res_t out_data
);

	logic          head_vld_q, skid_vld_q;
	bps_pkg::res_t head_q, skid_q;
	logic          pop;

	assign pop        = head_vld_q && out_ready;
	assign push_ready = !skid_vld_q;
	assign out_valid  = head_vld_q;
	assign out_data   = head_q;

	// hold control: two-entry queue, head then skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (skid_vld_q) begin
				if (pop) skid_vld_q <= 1'b0;
			end else if (head_vld_q) begin
				if (push && !pop) skid_vld_q <= 1'b1;
			end else begin
				head_vld_q <= push;
			end
			if (head_vld_q && pop && !skid_vld_q && !push) head_vld_q <= 1'b0;
		end
	end

	// move payload: refill the head from the skid or the new transfer
	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (pop) head_q <= skid_q;
		end else if (!head_vld_q || pop) begin
			if (push) head_q <= push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

>>> design/biphasic_pulse_sequencer_top.sv
// Biphasic pulse sequencer. One input transfer is one 100 us tick; every
// tick yields exactly one result transfer, in order. A tick is taken in every
// cycle the output queue has room: the whole tick is evaluated combinationally
// by the phase logic from the state registers into a two-entry output queue,
// so the block sustains one tick per clock while the queue has room and
// keeps accepting while one result waits downstream. The configuration
// port is always ready; write it only while no results are outstanding.
// Register indexes 0..6 follow the register list; writes to index 7 are ignored.
module biphasic_pulse_sequencer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        timer_advance,
	input  logic        flag_write,
	input  logic [7:0]  flag_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  drive,
	output logic [7:0]  level,
	output logic        sample_start,
	output logic        sample_store,
	output logic [1:0]  sample_slot,
	output logic        indicator,
	output logic        report,
	output logic [7:0]  run_flag,
	output logic [2:0]  phase,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	bps_pkg::cfg_t cfg;
	bps_pkg::res_t res, out_res;
	logic          step;

	assign cfg_ready = 1'b1;
	assign step      = in_valid && in_ready;

	bps_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bps_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.timer_advance (timer_advance),
		.flag_write    (flag_write),
		.flag_value    (flag_value),
		.cfg           (cfg),
		.res           (res)
	);

	bps_outbuf u_outbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (step),
		.push_data  (res),
		.push_ready (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_res)
	);

	// spread the result onto its ports
	assign drive        = out_res.drive;
	assign level        = out_res.level;
	assign sample_start = out_res.sample_start;
	assign sample_store = out_res.sample_store;
	assign sample_slot  = out_res.sample_slot;
	assign indicator    = out_res.indicator;
	assign report       = out_res.report;
	assign run_flag     = out_res.run_flag;
	assign phase        = out_res.phase;

endmodule

>>> design/bps_checker.sv
`include "biphasic_pulse_sequencer_top_macros.svh"

module bps_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] drive,
	input logic       indicator,
	input logic       report,
	input logic [2:0] phase
);

	// driving implies the pulse indicator is lit
	`BPS_ASSERT_NOW(a_drive_ind, out_valid && (drive != bps_pkg::DriveOff), indicator)

	// each polarity only while its own phase persists
	`BPS_ASSERT_NOW(a_drive_phase, out_valid && (drive != bps_pkg::DriveOff), ((drive == bps_pkg::DrivePos) && (phase == bps_pkg::PhPos)) || ((drive == bps_pkg::DriveNeg) && (phase == bps_pkg::PhNeg)))

	// a report leaves the sequencer in period wait or the next pulse
	`BPS_ASSERT_NOW(a_report_phase, out_valid && report, (phase == bps_pkg::PhPeriod) || (phase == bps_pkg::PhPos))

	// a stalled result holds
	`BPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(drive) && $stable(phase))

endmodule

bind biphasic_pulse_sequencer_top bps_checker u_bps_checker (.*);

>>> tb/tb_biphasic_pulse_sequencer_top.sv
module tb_biphasic_pulse_sequencer_top;

	localparam int StallLimit = 1000;
	localparam int RandomSettings = 12;
	localparam int TicksPerSetting = 150;
	localparam int HoldCycles = 48;
	localparam int DrainCycles = 10;
	// ticks sent after the start tick in the long-wait test
	localparam int LongWaitTicks = 48;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        timer_advance;
	logic        flag_write;
	logic [7:0]  flag_value;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  drive;
	logic [7:0]  level;
	logic        sample_start;
	logic        sample_store;
	logic [1:0]  sample_slot;
	logic        indicator;
	logic        report;
	logic [7:0]  run_flag;
	logic [2:0]  phase;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	// tracked copy of the sequencer state and registers
	bps_pkg::cfg_t                trk_cfg;
	logic [2:0]                   trk_phase;
	logic [7:0]                   trk_flag;
	logic [bps_pkg::TimeBits-1:0] trk_timer;
	logic [bps_pkg::TimeBits-1:0] trk_mark;
	logic [15:0]                  trk_ticks;

	bps_pkg::res_t pulse_outputs_due[$];
	int   ticks_sent = 0;
	int   results_seen = 0;
	int   failures = 0;
	int   quiet_cycles = 0;
	int   hold_len;
	bit   gaps_on;

	biphasic_pulse_sequencer_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.timer_advance(timer_advance),
		.flag_write   (flag_write),
		.flag_value   (flag_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.drive        (drive),
		.level        (level),
		.sample_start (sample_start),
		.sample_store (sample_store),
		.sample_slot  (sample_slot),
		.indicator    (indicator),
		.report       (report),
		.run_flag     (run_flag),
		.phase        (phase),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	task automatic reset_tracker();
		trk_cfg.pre_wait_time  = 16'd1000;
		trk_cfg.positive_width = 16'd50;
		trk_cfg.gap_width      = 16'd50;
		trk_cfg.negative_width = 16'd50;
		trk_cfg.pulse_period   = 16'd1000;
		trk_cfg.positive_level = 8'd25;
		trk_cfg.negative_level = 8'd25;
		trk_phase = bps_pkg::PhIdle;
		trk_flag  = bps_pkg::FlagOff;
		trk_timer = '0;
		trk_mark  = '0;
		trk_ticks = '0;
	endtask

	// Advance the tracked sequencer by one 100 us tick and return its outputs.
	function automatic bps_pkg::res_t next_pulse_outputs(input logic adv, input logic fw,
			input logic [7:0] fv);
		bps_pkg::res_t                r;
		logic [bps_pkg::TimeBits-1:0] since_mark;
		r = '0;
		if (fw)
			trk_flag = fv;
		if (adv)
			trk_timer = trk_timer + 1'b1;
		since_mark = trk_timer - trk_mark;
		// an off or out-of-range flag aborts whatever is running
		if (trk_flag == bps_pkg::FlagOff || trk_flag > bps_pkg::FlagMax)
			trk_phase = bps_pkg::PhIdle;
		case (trk_phase)
		bps_pkg::PhIdle: begin
			if (trk_flag == bps_pkg::FlagStart) begin
				trk_phase = bps_pkg::PhPreWait;
				trk_mark  = trk_timer;
			end else begin
				trk_flag = bps_pkg::FlagOff;
			end
		end
		bps_pkg::PhPreWait: begin
			if (since_mark >= trk_cfg.pre_wait_time) begin
				trk_flag  = bps_pkg::FlagRun;
				trk_mark  = trk_timer;
				trk_phase = bps_pkg::PhPos;
				trk_ticks = '0;
			end
		end
		bps_pkg::PhPos: begin
			r.indicator = 1'b1;
			r.level     = trk_cfg.positive_level;
			if (trk_ticks >= trk_cfg.positive_width) begin
				r.sample_store = 1'b1;
				r.sample_slot  = bps_pkg::Slot0;
				r.sample_start = 1'b1;
				trk_phase      = bps_pkg::PhGap;
				trk_ticks      = '0;
			end else begin
				r.drive        = bps_pkg::DrivePos;
				r.sample_start = (trk_ticks == 16'd0);
				trk_ticks      = trk_ticks + 1'b1;
			end
		end
		bps_pkg::PhGap: begin
			r.indicator = 1'b1;
			if (trk_ticks >= trk_cfg.gap_width) begin
				r.sample_store = 1'b1;
				r.sample_slot  = bps_pkg::Slot1;
				r.level        = trk_cfg.negative_level;
				trk_ticks      = '0;
				if (trk_cfg.negative_width != 16'd0) begin
					trk_phase = bps_pkg::PhNeg;
				end else begin
					// no negative phase: the pulse ends here
					trk_phase = bps_pkg::PhPeriod;
					trk_mark  = trk_timer;
					r.report  = 1'b1;
				end
			end else begin
				r.level   = trk_cfg.positive_level;
				trk_ticks = trk_ticks + 1'b1;
			end
		end
		bps_pkg::PhNeg: begin
			r.indicator = 1'b1;
			r.level     = trk_cfg.negative_level;
			if (trk_ticks >= trk_cfg.negative_width) begin
				r.sample_store = 1'b1;
				r.sample_slot  = bps_pkg::Slot2;
				r.sample_start = 1'b1;
				trk_phase      = bps_pkg::PhPeriod;
				trk_mark       = trk_timer;
				trk_ticks      = 16'd1;
			end else begin
				r.drive        = bps_pkg::DriveNeg;
				r.sample_start = (trk_ticks == 16'd0);
				trk_ticks      = trk_ticks + 1'b1;
			end
		end
		bps_pkg::PhPeriod: begin
			// slot 3 store is still owed after a negative phase
			if (trk_ticks == 16'd1) begin
				r.sample_store = 1'b1;
				r.sample_slot  = bps_pkg::Slot3;
				r.report       = 1'b1;
				trk_ticks      = '0;
			end
			if (since_mark >= trk_cfg.pulse_period) begin
				trk_phase = bps_pkg::PhPos;
				trk_mark  = trk_timer;
				trk_ticks = '0;
			end
		end
		default: trk_phase = bps_pkg::PhIdle;
		endcase
		r.run_flag = trk_flag;
		r.phase    = trk_phase;
		return r;
	endfunction

	// Offer one tick, hold it until the transfer, then record what it should yield.
	task automatic send_tick(input logic adv, input logic fw, input logic [7:0] fv);
		int gap;
		gap = gaps_on ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid      = 1'b1;
		timer_advance = adv;
		flag_write    = fw;
		flag_value    = fv;
		do @(posedge clk); while (!in_ready);
		pulse_outputs_due.push_back(next_pulse_outputs(adv, fw, fv));
		ticks_sent++;
	endtask

	// Write one register once every outstanding result has arrived.
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
		@(negedge clk);
		in_valid = 1'b0;
		wait (results_seen == ticks_sent);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
		bps_pkg::RegPreWait: trk_cfg.pre_wait_time  = data;
		bps_pkg::RegPosW:    trk_cfg.positive_width = data;
		bps_pkg::RegGapW:    trk_cfg.gap_width      = data;
		bps_pkg::RegNegW:    trk_cfg.negative_width = data;
		bps_pkg::RegPeriod:  trk_cfg.pulse_period   = data;
		bps_pkg::RegPosLvl:  trk_cfg.positive_level = data[7:0];
		bps_pkg::RegNegLvl:  trk_cfg.negative_level = data[7:0];
		default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic load_settings(input bps_pkg::cfg_t c);
		write_reg(bps_pkg::RegPreWait, c.pre_wait_time);
		write_reg(bps_pkg::RegPosW, c.positive_width);
		write_reg(bps_pkg::RegGapW, c.gap_width);
		write_reg(bps_pkg::RegNegW, c.negative_width);
		write_reg(bps_pkg::RegPeriod, c.pulse_period);
		write_reg(bps_pkg::RegPosLvl, {8'h00, c.positive_level});
		write_reg(bps_pkg::RegNegLvl, {8'h00, c.negative_level});
	endtask

	function automatic logic [15:0] draw_width();
		int pick;
		pick = $urandom_range(0, 11);
		if (pick == 0)
			return 16'hFFFF;
		if (pick == 1)
			return 16'h0000;
		return 16'($urandom_range(1, 5));
	endfunction

	function automatic logic [7:0] draw_level();
		int pick;
		pick = $urandom_range(0, 7);
		if (pick == 0)
			return 8'h00;
		if (pick == 1)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic bps_pkg::cfg_t draw_settings();
		bps_pkg::cfg_t c;
		c.pre_wait_time  = 16'($urandom_range(0, 8));
		c.positive_width = draw_width();
		c.gap_width      = draw_width();
		c.negative_width = draw_width();
		c.pulse_period   = 16'($urandom_range(0, 10));
		c.positive_level = draw_level();
		c.negative_level = draw_level();
		return c;
	endfunction

	// Start the sequencer, then run mostly clean ticks with the odd flag write.
	task automatic run_random_ticks(input int count);
		int         i;
		int         pick;
		logic       adv;
		logic       fw;
		logic [7:0] fv;
		send_tick(1'b1, 1'b1, bps_pkg::FlagStart);
		for (i = 1; i < count; i++) begin
			adv  = ($urandom_range(0, 3) != 0);
			fw   = 1'b0;
			fv   = 8'($urandom_range(0, 255));
			pick = $urandom_range(0, 99);
			if (trk_phase == bps_pkg::PhIdle && pick < 20) begin
				fw = 1'b1;
				fv = bps_pkg::FlagStart;
			end else if (pick < 2) begin
				fw = 1'b1;
				fv = bps_pkg::FlagOff;
			end else if (pick < 4) begin
				fw = 1'b1;
				fv = bps_pkg::FlagStart;
			end else if (pick < 5) begin
				fw = 1'b1;
				fv = bps_pkg::FlagRun;
			end else if (pick < 6) begin
				fw = 1'b1;
				fv = bps_pkg::FlagMax;
			end else if (pick < 8) begin
				fw = 1'b1;
				fv = 8'($urandom_range(int'(bps_pkg::FlagMax) + 1, 255));
			end
			send_tick(adv, fw, fv);
		end
	endtask

	// Reset values: non-start flags are cleared in idle, an off flag aborts the pre-wait.
	task automatic test_reset_values();
		send_tick(1'b0, 1'b1, bps_pkg::FlagRun);
		send_tick(1'b1, 1'b1, 8'hC8);
		send_tick(1'b0, 1'b1, bps_pkg::FlagMax);
		send_tick(1'b1, 1'b1, bps_pkg::FlagStart);
		send_tick(1'b1, 1'b0, 8'hFF);
		send_tick(1'b0, 1'b1, bps_pkg::FlagOff);
	endtask

	// All widths and waits zero: every phase collapses to its boundary tick.
	task automatic test_zero_widths();
		bps_pkg::cfg_t c;
		int            i;
		c = '0;
		c.positive_level = 8'hFF;
		c.negative_level = 8'hFF;
		load_settings(c);
		send_tick(1'b0, 1'b1, bps_pkg::FlagStart);
		for (i = 0; i < 5; i++)
			send_tick(1'b0, 1'b0, 8'h00);
		send_tick(1'b1, 1'b1, 8'hFF);
	endtask

	// One full pulse with a flag of 3 mid-pulse, then an out-of-range flag aborts the period wait.
	task automatic test_pulse_and_abort();
		bps_pkg::cfg_t c;
		int            i;
		c.pre_wait_time  = 16'd1;
		c.positive_width = 16'd2;
		c.gap_width      = 16'd1;
		c.negative_width = 16'd2;
		c.pulse_period   = 16'd2;
		c.positive_level = 8'h00;
		c.negative_level = 8'hFF;
		load_settings(c);
		send_tick(1'b1, 1'b1, bps_pkg::FlagStart);
		for (i = 0; i < 9; i++)
			send_tick(i != 2, i == 5, (i == 5) ? bps_pkg::FlagMax : 8'h00);
		send_tick(1'b1, 1'b1, bps_pkg::FlagMax + 8'd1);
	endtask

	task automatic test_random_settings();
		int n;
		for (n = 0; n < RandomSettings; n++) begin
			load_settings(draw_settings());
			gaps_on = ($urandom_range(0, 3) != 0);
			run_random_ticks(TicksPerSetting);
		end
		gaps_on = 1'b1;
	endtask

	// Hold the result side off so the output queue fills and ticks back up.
	task automatic test_backpressure();
		bps_pkg::cfg_t c;
		c = draw_settings();
		c.positive_width = 16'd3;
		c.negative_width = 16'd2;
		load_settings(c);
		hold_len = HoldCycles;
		run_random_ticks(80);
	endtask

	// Maximum period: after one short pulse the sequencer sits in the period wait.
	task automatic test_long_waits();
		bps_pkg::cfg_t c;
		int            i;
		c.pre_wait_time  = 16'd2;
		c.positive_width = 16'd1;
		c.gap_width      = 16'd0;
		c.negative_width = 16'd1;
		c.pulse_period   = 16'hFFFF;
		c.positive_level = 8'hFF;
		c.negative_level = 8'h00;
		load_settings(c);
		gaps_on = 1'b0;
		send_tick(1'b1, 1'b1, bps_pkg::FlagStart);
		for (i = 0; i < LongWaitTicks; i++)
			send_tick(1'b1, 1'b0, 8'($urandom_range(0, 255)));
		gaps_on = 1'b1;
	endtask

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endtask

	// Compare each result transfer with the oldest outstanding expectation.
	always @(posedge clk) begin : check_results
		bps_pkg::res_t want;
		if (arst_n === 1'b1 && out_valid && out_ready) begin
			if (pulse_outputs_due.size() == 0) begin
				$error("result transfer with no tick outstanding");
				failures++;
			end else begin
				want = pulse_outputs_due.pop_front();
				results_seen++;
				check_field("drive", 8'(want.drive), 8'(drive));
				check_field("level", want.level, level);
				check_field("sample_start", 8'(want.sample_start), 8'(sample_start));
				check_field("sample_store", 8'(want.sample_store), 8'(sample_store));
				check_field("sample_slot", 8'(want.sample_slot), 8'(sample_slot));
				check_field("indicator", 8'(want.indicator), 8'(indicator));
				check_field("report", 8'(want.report), 8'(report));
				check_field("run_flag", want.run_flag, run_flag);
				check_field("phase", 8'(want.phase), 8'(phase));
			end
		end
	end

	// Drive the result side: random stalls, or one long hold when requested.
	always begin : accept_results
		int stall;
		wait (arst_n === 1'b1);
		if (hold_len > 0) begin
			stall    = hold_len;
			hold_len = 0;
		end else begin
			stall = gaps_on ? $urandom_range(0, 4) : 0;
		end
		if (stall > 0) begin
			@(negedge clk);
			out_ready = 1'b0;
			repeat (stall - 1) @(negedge clk);
		end
		@(negedge clk);
		out_ready = 1'b1;
		do @(posedge clk); while (!out_valid);
	end

	// Abort if no transfer happens on any channel for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallLimit) begin
			$display("biphasic_pulse_sequencer_top regression: fail");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		timer_advance = 1'b0;
		flag_write    = 1'b0;
		flag_value    = 8'h00;
		cfg_valid     = 1'b0;
		cfg_index     = bps_pkg::RegPreWait;
		cfg_data      = 16'h0000;
		gaps_on       = 1'b1;
		hold_len      = 0;
		reset_tracker();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_values();
		test_zero_widths();
		test_pulse_and_abort();
		test_random_settings();
		test_backpressure();
		test_long_waits();

		// drain, then watch for any stray result
		@(negedge clk);
		in_valid = 1'b0;
		wait (results_seen == ticks_sent);
		repeat (DrainCycles) @(posedge clk);
		if (pulse_outputs_due.size() != 0) begin
			$error("%0d expected results never arrived", pulse_outputs_due.size());
			failures++;
		end
		if (failures == 0)
			$display("biphasic_pulse_sequencer_top regression: pass");
		else
			$display("biphasic_pulse_sequencer_top regression: fail");
		$finish;
	end

endmodule
